>>> hw/rtl/mer_pkg.sv
// shared types, widths and command codes of the midpoint ellipse rasterizer
`default_nettype none

package mer_pkg;

   // widths of the item fields
   localparam int RADIUS_WIDTH = 10;
   localparam int COORD_WIDTH  = 12;
   localparam int COLOR_WIDTH  = 24;
   localparam int PIX_W        = 14;

   // request and response bus widths, padded to whole bytes
   localparam int REQ_FIELDS_W = 2 * RADIUS_WIDTH + 2 * COORD_WIDTH + COLOR_WIDTH;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 8 * PIX_W + COLOR_WIDTH;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // internal arithmetic widths
   localparam int SQ_W   = 2 * RADIUS_WIDTH;       // rx^2, ry^2
   localparam int RR_W   = 4 * RADIUS_WIDTH;       // rx^2 * ry^2
   localparam int X_W    = RADIUS_WIDTH + 1;
   localparam int Y_W    = RADIUS_WIDTH + 2;
   localparam int GRAD_W = 3 * RADIUS_WIDTH + 3;
   localparam int MUL_W  = 2 * RADIUS_WIDTH + 4;
   localparam int PROD_W = 2 * MUL_W;
   localparam int DEC_W  = PROD_W;

   // selector carried in tuser
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_RX_RX,
      MUL_RY_RY,
      MUL_RX2_RY,
      MUL_RX2_RY2,
      MUL_AX_AX,
      MUL_AY_AY,
      MUL_RY2_T,
      MUL_RX2_T
   } mul_sel_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SET_RX2,
      OP_SET_RY2,
      OP_INIT,
      OP_SET_RR,
      OP_SAVE_T,
      OP_DEC_A,
      OP_DEC_B,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      dp_op_type   op;
   } dp_cmd_type;

   typedef struct packed {
      logic busy;
      logic need_switch;
      logic out_free;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_RX,
      ST_SQ_RY,
      ST_RX2_RY,
      ST_RR,
      ST_SAVE_RR,
      ST_SW_AX,
      ST_SW_AY,
      ST_SW_MUL_A,
      ST_SW_MUL_B,
      ST_SW_ADD,
      ST_EMIT
   } ctrl_state_type;

endpackage

`default_nettype wire

>>> hw/rtl/mer_ctrl.sv
// sequencing state machine of the midpoint ellipse rasterizer
`default_nettype none

module mer_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire                     req_tuser,
   input  mer_pkg::dp_status_type  dp_status,
   output mer_pkg::dp_cmd_type     dp_cmd
);
   import mer_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      dp_cmd.mul_sel = MUL_NONE;
      dp_cmd.op      = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == CMD_START) begin
                  dp_cmd.op = OP_LOAD;
                  state_in  = ST_SQ_RX;
               end else if (dp_status.busy) begin
                  if (dp_status.need_switch) begin
                     state_in = ST_SW_AX;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_SQ_RX: begin
            dp_cmd.mul_sel = MUL_RX_RX;
            state_in       = ST_SQ_RY;
         end
         ST_SQ_RY: begin
            dp_cmd.mul_sel = MUL_RY_RY;
            dp_cmd.op      = OP_SET_RX2;
            state_in       = ST_RX2_RY;
         end
         ST_RX2_RY: begin
            dp_cmd.mul_sel = MUL_RX2_RY;
            dp_cmd.op      = OP_SET_RY2;
            state_in       = ST_RR;
         end
         ST_RR: begin
            dp_cmd.mul_sel = MUL_RX2_RY2;
            dp_cmd.op      = OP_INIT;
            state_in       = ST_SAVE_RR;
         end
         ST_SAVE_RR: begin
            dp_cmd.op = OP_SET_RR;
            state_in  = ST_IDLE;
         end
         ST_SW_AX: begin
            dp_cmd.mul_sel = MUL_AX_AX;
            state_in       = ST_SW_AY;
         end
         ST_SW_AY: begin
            dp_cmd.mul_sel = MUL_AY_AY;
            dp_cmd.op      = OP_SAVE_T;
            state_in       = ST_SW_MUL_A;
         end
         ST_SW_MUL_A: begin
            dp_cmd.mul_sel = MUL_RY2_T;
            dp_cmd.op      = OP_SAVE_T;
            state_in       = ST_SW_MUL_B;
         end
         ST_SW_MUL_B: begin
            dp_cmd.mul_sel = MUL_RX2_T;
            dp_cmd.op      = OP_DEC_A;
            state_in       = ST_SW_ADD;
         end
         ST_SW_ADD: begin
            dp_cmd.op = OP_DEC_B;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (dp_status.out_free) begin
               dp_cmd.op = OP_EMIT;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/mer_datapath.sv
// registers, shared multiplier and step arithmetic of the ellipse rasterizer
`default_nettype none

module mer_datapath (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  [mer_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  mer_pkg::dp_cmd_type                 dp_cmd,
   output mer_pkg::dp_status_type              dp_status,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [mer_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tlast
);
   import mer_pkg::*;

   localparam int RY_LO = RADIUS_WIDTH;
   localparam int CX_LO = 2 * RADIUS_WIDTH;
   localparam int CY_LO = CX_LO + COORD_WIDTH;
   localparam int CL_LO = CY_LO + COORD_WIDTH;

   logic [RADIUS_WIDTH-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [COORD_WIDTH-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [COLOR_WIDTH-1:0]  color_ff, color_in;
   logic [SQ_W-1:0]         rx2_ff, rx2_in, ry2_ff, ry2_in;
   logic [RR_W-1:0]         rr_ff, rr_in;
   logic [MUL_W-1:0]        t_ff, t_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic                    busy_ff, busy_in, r2_ff, r2_in;
   logic [X_W-1:0]          x_ff, x_in;
   logic [Y_W-1:0]          y_ff, y_in;
   logic [GRAD_W-1:0]       gx_ff, gx_in, gy_ff, gy_in;
   logic [DEC_W-1:0]        dec_ff, dec_in;
   logic                    vld_ff, vld_in;
   logic [RSP_DATA_W-1:0]   data_ff, data_in;
   logic                    last_ff, last_in;

   logic [MUL_W-1:0]        mul_a, mul_b;
   logic [X_W:0]            ax;
   logic [Y_W-1:0]          ay;
   logic [GRAD_W-1:0]       gx_n, gy_n;
   logic                    last;
   logic [PIX_W-1:0]        px_r, px_l, py_lo, py_up;

   // shared multiplier, product registered every cycle
   always_comb begin
      ax = {x_ff, 1'b1};
      ay = (y_ff == '0) ? Y_W'(1) : y_ff - Y_W'(1);
      case (dp_cmd.mul_sel)
         MUL_RX_RX: begin
            mul_a = MUL_W'(rx_ff);
            mul_b = MUL_W'(rx_ff);
         end
         MUL_RY_RY: begin
            mul_a = MUL_W'(ry_ff);
            mul_b = MUL_W'(ry_ff);
         end
         MUL_RX2_RY: begin
            mul_a = MUL_W'(rx2_ff);
            mul_b = MUL_W'(ry_ff);
         end
         MUL_RX2_RY2: begin
            mul_a = MUL_W'(rx2_ff);
            mul_b = MUL_W'(ry2_ff);
         end
         MUL_AX_AX: begin
            mul_a = MUL_W'(ax);
            mul_b = MUL_W'(ax);
         end
         MUL_AY_AY: begin
            mul_a = MUL_W'(ay);
            mul_b = MUL_W'(ay);
         end
         MUL_RY2_T: begin
            mul_a = MUL_W'(ry2_ff);
            mul_b = t_ff;
         end
         MUL_RX2_T: begin
            mul_a = MUL_W'(rx2_ff);
            mul_b = t_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // pixel group of the current point
   always_comb begin
      gx_n  = gx_ff + (GRAD_W'(ry2_ff) << 1);
      gy_n  = gy_ff - (GRAD_W'(rx2_ff) << 1);
      last  = r2_ff && (y_ff == '0);
      px_r  = PIX_W'(cx_ff) + PIX_W'(x_ff);
      px_l  = PIX_W'(cx_ff) - PIX_W'(x_ff);
      py_lo = PIX_W'(cy_ff) + PIX_W'(y_ff);
      py_up = PIX_W'(cy_ff) - PIX_W'(y_ff);
   end

   always_comb begin
      rx_in    = rx_ff;
      ry_in    = ry_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      color_in = color_ff;
      rx2_in   = rx2_ff;
      ry2_in   = ry2_ff;
      rr_in    = rr_ff;
      t_in     = t_ff;
      busy_in  = busy_ff;
      r2_in    = r2_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      gx_in    = gx_ff;
      gy_in    = gy_ff;
      dec_in   = dec_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      vld_in   = vld_ff && !rsp_tready;
      case (dp_cmd.op)
         OP_LOAD: begin
            rx_in    = req_tdata[RY_LO-1:0];
            ry_in    = req_tdata[CX_LO-1:RY_LO];
            cx_in    = req_tdata[CY_LO-1:CX_LO];
            cy_in    = req_tdata[CL_LO-1:CY_LO];
            color_in = req_tdata[CL_LO+COLOR_WIDTH-1:CL_LO];
         end
         OP_SET_RX2: rx2_in = SQ_W'(prod_ff);
         OP_SET_RY2: ry2_in = SQ_W'(prod_ff);
         OP_SET_RR:  rr_in  = RR_W'(prod_ff);
         OP_SAVE_T:  t_in   = MUL_W'(prod_ff);
         OP_INIT: begin
            // 4*(ry^2 - rx^2*ry) + rx^2
            busy_in = 1'b1;
            r2_in   = 1'b0;
            x_in    = '0;
            y_in    = Y_W'(ry_ff);
            gx_in   = '0;
            gy_in   = GRAD_W'(prod_ff) << 1;
            dec_in  = (DEC_W'(ry2_ff) << 2) - (prod_ff << 2) + DEC_W'(rx2_ff);
         end
         OP_DEC_A: begin
            dec_in = prod_ff - (DEC_W'(rr_ff) << 2);
         end
         OP_DEC_B: begin
            dec_in = dec_ff + (prod_ff << 2);
            r2_in  = 1'b1;
         end
         OP_EMIT: begin
            vld_in  = 1'b1;
            last_in = last;
            data_in = RSP_DATA_W'({color_ff, py_up, px_l, py_up, px_r,
                                   py_lo, px_l, py_lo, px_r});
            if (!r2_ff) begin
               x_in  = x_ff + X_W'(1);
               gx_in = gx_n;
               if (dec_ff[DEC_W-1]) begin
                  dec_in = dec_ff + ((DEC_W'(gx_n) + DEC_W'(ry2_ff)) << 2);
               end else begin
                  y_in   = y_ff - Y_W'(1);
                  gy_in  = gy_n;
                  dec_in = dec_ff
                           + ((DEC_W'(gx_n) - DEC_W'(gy_n) + DEC_W'(ry2_ff)) << 2);
               end
            end else begin
               y_in  = y_ff - Y_W'(1);
               gy_in = gy_n;
               if (dec_ff != '0 && !dec_ff[DEC_W-1]) begin
                  dec_in = dec_ff + ((DEC_W'(rx2_ff) - DEC_W'(gy_n)) << 2);
               end else begin
                  x_in   = x_ff + X_W'(1);
                  gx_in  = gx_n;
                  dec_in = dec_ff
                           + ((DEC_W'(gx_n) - DEC_W'(gy_n) + DEC_W'(rx2_ff)) << 2);
               end
               if (last) begin
                  busy_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         r2_ff   <= 1'b0;
         vld_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         r2_ff   <= r2_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      color_ff <= color_in;
      rx2_ff   <= rx2_in;
      ry2_ff   <= ry2_in;
      rr_ff    <= rr_in;
      t_ff     <= t_in;
      prod_ff  <= prod_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      gx_ff    <= gx_in;
      gy_ff    <= gy_in;
      dec_ff   <= dec_in;
      data_ff  <= data_in;
      last_ff  <= last_in;
   end

   assign dp_status.busy        = busy_ff;
   assign dp_status.need_switch = !r2_ff && !(gx_ff < gy_ff);
   assign dp_status.out_free    = !vld_ff || rsp_tready;

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

>>> hw/rtl/midpoint_ellipse_rasterizer.sv
// top level of the midpoint ellipse rasterizer: controller, datapath and checks
`default_nettype none

// Midpoint ellipse rasterizer. A start transfer (tuser = 0) loads radii,
// center and color and produces no response; each step transfer (tuser = 1)
// produces one response holding the four mirror pixels of the current point
// and then moves to the next point, region 1 while the x gradient is below
// the y gradient, region 2 after that. The response of the point with y = 0
// in region 2 carries tlast, after which steps are dropped until the next
// start. A step with no ellipse in progress is taken and gives nothing. A
// start may be issued at any time and drops the ellipse in progress. After
// its transfer a start runs the setup states (squares of the radii and their
// products, all through one shared 24 x 24 multiplier); a plain step is its
// transfer plus the output register load; the single step that crosses into
// region 2 also passes the switch states, as it recomputes the decision
// value through that same multiplier. Requests are taken while a response
// waits in the output register; a step then holds until that register
// frees. Coordinates are 14-bit two's complement and are not clipped.
module midpoint_ellipse_rasterizer (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // radius_x, radius_y, center_x, center_y, pixel_color, zero pad
   input  wire  [mer_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd
   input  wire                              req_tuser,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // px_right, py_lower, px_left, py_lower_left, px_right_upper,
   // py_upper, px_left_upper, py_upper_left, out_color
   output logic [mer_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // is_last
   output logic                             rsp_tlast
);
   import mer_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // sequencing of start setup, region switch and output
   mer_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd)
   );

   // ellipse state, multiplier and output register
   mer_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // output register is only loaded when it is free
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == OP_EMIT) |-> dp_status.out_free)
      else $error("response loaded over a pending transfer");

   // a loaded response is offered on the next cycle
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == OP_EMIT) |=> rsp_tvalid)
      else $error("response not offered after load");

   // a start transfer has an ellipse in progress once setup is done
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == CMD_START) |-> ##5 dp_status.busy)
      else $error("start setup did not arm the rasterizer");

endmodule

`default_nettype wire

>>> sim/midpoint_ellipse_rasterizer_tb.sv
// self-checking regression bench for the midpoint ellipse rasterizer
`timescale 1ns / 100ps

module midpoint_ellipse_rasterizer_tb;

   import mer_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 9;
   localparam int RANDOM_ITEMS  = 340;
   localparam int SETTLE_CYCLES = 24;      // longer than the longest internal sequence
   localparam int STUCK_LIMIT   = 2000;    // cycles with no transfer on either side

   // bit offsets of the request fields inside req_tdata
   localparam int RY_LSB    = RADIUS_WIDTH;
   localparam int CX_LSB    = 2 * RADIUS_WIDTH;
   localparam int CY_LSB    = CX_LSB + COORD_WIDTH;
   localparam int COLOR_LSB = CY_LSB + COORD_WIDTH;

   typedef logic [RADIUS_WIDTH-1:0] radius_t;
   typedef logic [COORD_WIDTH-1:0]  coord_t;
   typedef logic [COLOR_WIDTH-1:0]  color_t;
   typedef logic [REQ_DATA_W-1:0]   req_word_t;

   // one response, laid out so that {tlast, tdata} maps onto it directly
   typedef struct packed {
      logic             is_last;
      color_t           out_color;
      logic [PIX_W-1:0] py_upper_left;
      logic [PIX_W-1:0] px_left_upper;
      logic [PIX_W-1:0] py_upper;
      logic [PIX_W-1:0] px_right_upper;
      logic [PIX_W-1:0] py_lower_left;
      logic [PIX_W-1:0] px_left;
      logic [PIX_W-1:0] py_lower;
      logic [PIX_W-1:0] px_right;
   } pixel_group_t;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   req_word_t             req_tdata  = '0;
   logic                  req_tuser  = CMD_START;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   midpoint_ellipse_rasterizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #HALF_PERIOD clock = ~clock;

   // tracing state of the ellipse as the block should hold it
   bit        trace_busy;
   bit        trace_region_two;
   bit [63:0] trace_x;
   bit [63:0] trace_y;
   bit [63:0] trace_grad_x;
   bit [63:0] trace_grad_y;
   bit [63:0] trace_decision;   // four times the midpoint decision value
   bit [63:0] trace_rx;
   bit [63:0] trace_ry;
   bit [63:0] trace_cx;
   bit [63:0] trace_cy;
   color_t    trace_color;

   pixel_group_t pending_pixel_groups[$];
   int           fail_count  = 0;
   int           live_items  = 0;    // starts and steps that hit a live ellipse
   int           burst_left  = 0;
   int           stuck_cycles = 0;

   // receiver stall pattern, reloaded after a random hold
   logic [15:0]  stall_pattern = 16'hffff;
   logic [3:0]   stall_phase   = '0;
   int           stall_hold    = 0;

   // work out what one accepted request should produce and move the trace on
   function automatic void advance_ellipse(input logic cmd, input req_word_t payload);
      bit [63:0]    rx2, ry2, ax, ay;
      bit [63:0]    x_plus, x_minus, y_plus, y_minus;
      bit           final_group;
      pixel_group_t group;
      if (cmd == CMD_START) begin
         trace_rx    = 64'(payload[0 +: RADIUS_WIDTH]);
         trace_ry    = 64'(payload[RY_LSB +: RADIUS_WIDTH]);
         trace_cx    = 64'(payload[CX_LSB +: COORD_WIDTH]);
         trace_cy    = 64'(payload[CY_LSB +: COORD_WIDTH]);
         trace_color = payload[COLOR_LSB +: COLOR_WIDTH];
         rx2 = trace_rx * trace_rx;
         ry2 = trace_ry * trace_ry;
         trace_busy       = 1'b1;
         trace_region_two = 1'b0;
         trace_x          = 64'd0;
         trace_y          = trace_ry;
         trace_grad_x     = 64'd0;
         trace_grad_y     = 64'd2 * rx2 * trace_ry;
         // ry^2 - rx^2*ry + rx^2/4, scaled by four
         trace_decision   = 64'd4 * ry2 - 64'd4 * rx2 * trace_ry + rx2;
         return;
      end
      if (!trace_busy)
         return;
      rx2 = trace_rx * trace_rx;
      ry2 = trace_ry * trace_ry;
      // hand over to region 2 once the x gradient catches up
      if (!trace_region_two && !(trace_grad_x < trace_grad_y)) begin
         ax = 64'd2 * trace_x + 64'd1;
         ay = trace_y - 64'd1;
         trace_decision   = ry2 * ax * ax + 64'd4 * rx2 * ay * ay - 64'd4 * rx2 * ry2;
         trace_region_two = 1'b1;
      end
      final_group = trace_region_two && (trace_y == 64'd0);
      x_plus  = trace_cx + trace_x;
      x_minus = trace_cx - trace_x;
      y_plus  = trace_cy + trace_y;
      y_minus = trace_cy - trace_y;
      group.px_right       = x_plus[PIX_W-1:0];
      group.py_lower       = y_plus[PIX_W-1:0];
      group.px_left        = x_minus[PIX_W-1:0];
      group.py_lower_left  = y_plus[PIX_W-1:0];
      group.px_right_upper = x_plus[PIX_W-1:0];
      group.py_upper       = y_minus[PIX_W-1:0];
      group.px_left_upper  = x_minus[PIX_W-1:0];
      group.py_upper_left  = y_minus[PIX_W-1:0];
      group.out_color      = trace_color;
      group.is_last        = final_group;
      pending_pixel_groups.push_back(group);
      if (!trace_region_two) begin
         trace_x      = trace_x + 64'd1;
         trace_grad_x = trace_grad_x + 64'd2 * ry2;
         if (trace_decision[63]) begin
            trace_decision = trace_decision + 64'd4 * (trace_grad_x + ry2);
         end else begin
            trace_y        = trace_y - 64'd1;
            trace_grad_y   = trace_grad_y - 64'd2 * rx2;
            trace_decision = trace_decision + 64'd4 * (trace_grad_x - trace_grad_y + ry2);
         end
      end else begin
         trace_y      = trace_y - 64'd1;
         trace_grad_y = trace_grad_y - 64'd2 * rx2;
         if (trace_decision != 64'd0 && !trace_decision[63]) begin
            trace_decision = trace_decision + 64'd4 * (rx2 - trace_grad_y);
         end else begin
            trace_x        = trace_x + 64'd1;
            trace_grad_x   = trace_grad_x + 64'd2 * ry2;
            trace_decision = trace_decision + 64'd4 * (trace_grad_x - trace_grad_y + rx2);
         end
         if (final_group)
            trace_busy = 1'b0;
      end
   endfunction

   function automatic req_word_t shape_item(input radius_t rx, input radius_t ry,
                                            input coord_t cx, input coord_t cy,
                                            input color_t color);
      return req_word_t'({color, cy, cx, ry, rx});
   endfunction

   // full-range fields; steps carry this as content the block must ignore
   function automatic req_word_t random_payload();
      return shape_item(radius_t'($urandom), radius_t'($urandom), coord_t'($urandom),
                        coord_t'($urandom), color_t'($urandom));
   endfunction

   // one request transfer, with bursts and random gaps on the sender side
   task automatic send_item(input logic cmd, input req_word_t payload);
      int unsigned gap_cycles;
      bit          taken;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap_cycles != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap_cycles) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= payload;
      // ready seen at the falling edge holds through the next rising edge
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      if (cmd == CMD_START || trace_busy)
         live_items++;
      advance_ellipse(cmd, payload);
   endtask

   task automatic trace_to_end();
      while (trace_busy)
         send_item(CMD_STEP, random_payload());
   endtask

   // steps with no ellipse loaded, straight out of reset
   task automatic test_step_while_idle();
      repeat (2) send_item(CMD_STEP, random_payload());
   endtask

   // zero radii on either axis or both
   task automatic test_degenerate_radii();
      send_item(CMD_START, shape_item(10'd0, 10'd0, 12'd100, 12'd200, 24'h123456));
      trace_to_end();
      send_item(CMD_START, shape_item(10'd0, 10'd3, 12'd7, 12'd1, 24'h00ff00));
      trace_to_end();
      send_item(CMD_START, shape_item(10'd6, 10'd0, 12'd2, 12'd4090, 24'hff0000));
      trace_to_end();
      // finished ellipse, so this step must be dropped
      send_item(CMD_STEP, random_payload());
   endtask

   // field extremes, each later start dropping the ellipse in progress
   task automatic test_field_extremes();
      send_item(CMD_START, shape_item('1, '1, '0, '0, '0));
      repeat (2) send_item(CMD_STEP, random_payload());
      send_item(CMD_START, shape_item('1, 10'd1, '1, '1, '1));
      repeat (2) send_item(CMD_STEP, random_payload());
      send_item(CMD_START, shape_item(10'd1, '1, 12'd2048, 12'd3, 24'haaaaaa));
      repeat (2) send_item(CMD_STEP, random_payload());
      send_item(CMD_START, shape_item(10'd2, 10'd3, 12'd4094, 12'd2, 24'h555555));
      trace_to_end();
   endtask

   // one mid-size ellipse traced all the way, coordinates going negative
   task automatic test_full_extent();
      send_item(CMD_START, shape_item(10'd90, 10'd70, '1, '0, color_t'($urandom)));
      trace_to_end();
   endtask

   // mostly complete small ellipses, some broken off, some noise
   task automatic test_random_ellipses();
      int kind;
      int steps;
      int live_at_start;
      live_at_start = live_items;
      while (live_items - live_at_start < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 19);
         if (kind == 0) begin
            repeat ($urandom_range(1, 4))
               send_item(logic'($urandom_range(0, 1)), random_payload());
         end else if (kind <= 2) begin
            // full-range radii, abandoned after a few points
            send_item(CMD_START, random_payload());
            repeat ($urandom_range(1, 20)) send_item(CMD_STEP, random_payload());
         end else begin
            send_item(CMD_START,
                      shape_item(radius_t'($urandom_range(0, (kind < 6) ? 40 : 12)),
                                 radius_t'($urandom_range(0, (kind < 6) ? 40 : 12)),
                                 coord_t'($urandom), coord_t'($urandom),
                                 color_t'($urandom)));
            // now and then cut the ellipse short with the next start
            steps = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : -1;
            while (trace_busy && steps != 0) begin
               send_item(CMD_STEP, random_payload());
               steps--;
            end
            repeat ($urandom_range(0, 1)) send_item(CMD_STEP, random_payload());
         end
      end
   endtask

   task automatic check_field(input string field_name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 'h%0h, got 'h%0h", field_name, want, got);
         fail_count++;
      end
   endtask

   // response stall pattern, one nonblocking update per edge
   always @(posedge clock) begin
      if (stall_hold == 0) begin
         stall_hold <= $urandom_range(32, 256);
         case ($urandom_range(0, 3))
            0: stall_pattern <= 16'hffff;                              // no stalls
            1: stall_pattern <= 16'($urandom) | 16'h0001;              // random
            2: stall_pattern <= 16'h0001 << $urandom_range(0, 15);     // long stalls
            default: stall_pattern <= 16'($urandom) | 16'($urandom);   // mostly ready
         endcase
      end else begin
         stall_hold <= stall_hold - 1;
      end
      stall_phase <= stall_phase + 4'd1;
      rsp_tready  <= stall_pattern[stall_phase];
   end

   // response check; a handshake seen at the falling edge completes at the next rise
   always @(negedge clock) begin : response_check
      pixel_group_t got;
      pixel_group_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tlast, rsp_tdata[RSP_FIELDS_W-1:0]};
         if (pending_pixel_groups.size() == 0) begin
            $error("response transfer with nothing expected: 'h%0h", got);
            fail_count++;
         end else begin
            want = pending_pixel_groups.pop_front();
            check_field("px_right", 32'(want.px_right), 32'(got.px_right));
            check_field("py_lower", 32'(want.py_lower), 32'(got.py_lower));
            check_field("px_left", 32'(want.px_left), 32'(got.px_left));
            check_field("py_lower_left", 32'(want.py_lower_left),
                        32'(got.py_lower_left));
            check_field("px_right_upper", 32'(want.px_right_upper),
                        32'(got.px_right_upper));
            check_field("py_upper", 32'(want.py_upper), 32'(got.py_upper));
            check_field("px_left_upper", 32'(want.px_left_upper),
                        32'(got.px_left_upper));
            check_field("py_upper_left", 32'(want.py_upper_left),
                        32'(got.py_upper_left));
            check_field("out_color", 32'(want.out_color), 32'(got.out_color));
            check_field("is_last", 32'(want.is_last), 32'(got.is_last));
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(negedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stuck_cycles = 0;
      else
         stuck_cycles = stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
         $display("midpoint_ellipse_rasterizer regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_step_while_idle();
      test_degenerate_radii();
      test_field_extremes();
      test_full_extent();
      test_random_ellipses();
      req_tvalid <= 1'b0;
      // drain, then give the block time to show any stray response
      while (pending_pixel_groups.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_pixel_groups.size() == 0)
         $display("midpoint_ellipse_rasterizer regression: pass");
      else
         $display("midpoint_ellipse_rasterizer regression: fail");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/mer_pkg.sv
hw/rtl/mer_ctrl.sv
hw/rtl/mer_datapath.sv
hw/rtl/midpoint_ellipse_rasterizer.sv
sim/midpoint_ellipse_rasterizer_tb.sv
